// ===== hdl/jbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the audio jitter buffer playout block.
package jbp_pkg;

	localparam int BLOCK_SAMPLES_DEF = 128;
	localparam int QUEUE_BLOCKS_DEF  = 16;
	localparam int FRAME_SAMPLES_DEF = 16;
	localparam int SAMPLE_W          = 16;
	localparam int THRESH_W          = 5;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd6;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_RUN,
		ST_SILENT
	} seq_state_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pcm_out;
		logic                       is_silence;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic valid;
		logic silent;
		logic last;
	} emit_t;

endpackage

// ===== hdl/jbp_addr_unit.sv =====
`timescale 1ns / 1ps
// Shared sample address generator: block slot times block length plus offset.
module jbp_addr_unit #(
	parameter int BLOCK_SAMPLES = 128,
	parameter int PHYS_W        = 5,
	parameter int POS_W         = 7,
	parameter int ADDR_W        = 12
) (
	input  logic [PHYS_W-1:0] phys,
	input  logic [POS_W-1:0]  off,
	output logic [ADDR_W-1:0] addr
);
	assign addr = ADDR_W'(ADDR_W'(phys) * ADDR_W'(BLOCK_SAMPLES)) + ADDR_W'(off);
endmodule

// ===== hdl/jbp_sample_mem.sv =====
`timescale 1ns / 1ps
// Sample store: one port, write or registered read each cycle.
module jbp_sample_mem #(
	parameter int DEPTH  = 2304,
	parameter int ADDR_W = 12
) (
	input  logic                          clk,
	input  jbp_pkg::mem_ctl_t             ctl,
	input  logic [ADDR_W-1:0]             addr,
	input  logic [jbp_pkg::SAMPLE_W-1:0]  wdata,
	output logic [jbp_pkg::SAMPLE_W-1:0]  rdata
);
	import jbp_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/jbp_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: queue bookkeeping, block slot remapping and frame emission.
module jbp_seq #(
	parameter int BLOCK_SAMPLES = 128,
	parameter int QUEUE_BLOCKS  = 16,
	parameter int FRAME_SAMPLES = 16,
	parameter int ADDR_W        = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  jbp_pkg::in_item_t             item,
	input  logic                          cfg_we,
	input  logic [jbp_pkg::THRESH_W-1:0]  cfg_data,
	output logic                          busy,
	output jbp_pkg::mem_ctl_t             mem_ctl,
	output logic [ADDR_W-1:0]             mem_addr,
	output logic [jbp_pkg::SAMPLE_W-1:0]  mem_wdata,
	output jbp_pkg::emit_t                emit
);
	import jbp_pkg::*;

	localparam int POS_W  = $clog2(BLOCK_SAMPLES);
	localparam int QIDX_W = $clog2(QUEUE_BLOCKS);
	localparam int CNT_W  = $clog2(QUEUE_BLOCKS + 1);
	localparam int PHYS_W = $clog2(QUEUE_BLOCKS + 2);
	localparam int FR_W   = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

	seq_state_t          state_q, state_d;
	logic [QIDX_W-1:0]   head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0]    queued_q, queued_d;
	logic [POS_W-1:0]    stage_cnt_q, stage_cnt_d, cur_pos_q, cur_pos_d;
	logic                cur_valid_q, cur_valid_d, streaming_q, streaming_d;
	logic [PHYS_W-1:0]   stage_phys_q, stage_phys_d, cur_phys_q, cur_phys_d;
	logic [PHYS_W-1:0]   map_q [QUEUE_BLOCKS];
	logic [PHYS_W-1:0]   map_d [QUEUE_BLOCKS];
	logic [FR_W-1:0]     frame_idx_q, frame_idx_d;
	logic [SAMPLE_W-1:0] sample_q, sample_d;
	logic [THRESH_W-1:0] thr_q;
	emit_t               emit_s1, emit_d;

	logic [QIDX_W-1:0]   map_idx;
	logic [PHYS_W-1:0]   map_rd;
	logic [PHYS_W-1:0]   au_phys;
	logic [POS_W-1:0]    au_off;
	logic                last_sample;
	logic [QIDX_W-1:0]   head_inc, tail_inc;

	jbp_addr_unit #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES),
		.PHYS_W        (PHYS_W),
		.POS_W         (POS_W),
		.ADDR_W        (ADDR_W)
	) u_addr (
		.phys (au_phys),
		.off  (au_off),
		.addr (mem_addr)
	);

	assign map_idx     = (state_q == ST_PUSH) ? tail_q : head_q;
	assign map_rd      = map_q[map_idx];
	assign last_sample = (frame_idx_q == FR_W'(FRAME_SAMPLES - 1));
	assign head_inc    = (head_q == QIDX_W'(QUEUE_BLOCKS - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc    = (tail_q == QIDX_W'(QUEUE_BLOCKS - 1)) ? '0 : tail_q + 1'b1;
	assign busy        = (state_q != ST_IDLE);
	assign mem_wdata   = sample_q;
	assign emit        = emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			queued_q     <= '0;
			stage_cnt_q  <= '0;
			cur_pos_q    <= '0;
			cur_valid_q  <= 1'b0;
			streaming_q  <= 1'b0;
			stage_phys_q <= PHYS_W'(QUEUE_BLOCKS);
			cur_phys_q   <= PHYS_W'(QUEUE_BLOCKS + 1);
			for (int i = 0; i < QUEUE_BLOCKS; i++) begin
				map_q[i] <= PHYS_W'(i);
			end
			frame_idx_q  <= '0;
			thr_q        <= THRESH_RESET;
			emit_s1      <= '0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			queued_q     <= queued_d;
			stage_cnt_q  <= stage_cnt_d;
			cur_pos_q    <= cur_pos_d;
			cur_valid_q  <= cur_valid_d;
			streaming_q  <= streaming_d;
			stage_phys_q <= stage_phys_d;
			cur_phys_q   <= cur_phys_d;
			map_q        <= map_d;
			frame_idx_q  <= frame_idx_d;
			emit_s1      <= emit_d;
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		sample_q <= sample_d;
	end

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		queued_d     = queued_q;
		stage_cnt_d  = stage_cnt_q;
		cur_pos_d    = cur_pos_q;
		cur_valid_d  = cur_valid_q;
		streaming_d  = streaming_q;
		stage_phys_d = stage_phys_q;
		cur_phys_d   = cur_phys_q;
		map_d        = map_q;
		frame_idx_d  = frame_idx_q;
		sample_d     = sample_q;
		emit_d       = '0;
		mem_ctl      = '0;
		au_phys      = cur_phys_q;
		au_off       = cur_pos_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (item.command)
						CMD_PUSH: begin
							sample_d = item.sample;
							state_d  = ST_PUSH;
						end
						CMD_TICK: begin
							frame_idx_d = '0;
							if (!streaming_q && (32'(queued_q) < 32'(thr_q))) begin
								state_d = ST_SILENT;
							end else begin
								streaming_d = 1'b1;
								state_d     = ST_RUN;
							end
						end
						CMD_FLUSH: begin
							head_d      = '0;
							tail_d      = '0;
							queued_d    = '0;
							stage_cnt_d = '0;
							cur_pos_d   = '0;
							cur_valid_d = 1'b0;
							streaming_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PUSH: begin
				au_phys       = stage_phys_q;
				au_off        = stage_cnt_q;
				mem_ctl.wr_en = 1'b1;
				if (stage_cnt_q == POS_W'(BLOCK_SAMPLES - 1)) begin
					// swap the full staging slot into the ring, drop oldest when full
					map_d[tail_q] = stage_phys_q;
					stage_phys_d  = map_rd;
					tail_d        = tail_inc;
					if (queued_q == CNT_W'(QUEUE_BLOCKS)) begin
						head_d = head_inc;
					end else begin
						queued_d = queued_q + 1'b1;
					end
					stage_cnt_d = '0;
				end else begin
					stage_cnt_d = stage_cnt_q + 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_RUN: begin
				if (cur_valid_q) begin
					mem_ctl.rd_en = 1'b1;
					emit_d.valid  = 1'b1;
					emit_d.last   = last_sample;
					if (cur_pos_q == POS_W'(BLOCK_SAMPLES - 1)) begin
						cur_pos_d   = '0;
						cur_valid_d = 1'b0;
					end else begin
						cur_pos_d = cur_pos_q + 1'b1;
					end
					if (last_sample) begin
						state_d = ST_IDLE;
					end else begin
						frame_idx_d = frame_idx_q + 1'b1;
					end
				end else if (queued_q != '0) begin
					// pop: swap the head slot out as the current block
					map_d[head_q] = cur_phys_q;
					cur_phys_d    = map_rd;
					head_d        = head_inc;
					queued_d      = queued_q - 1'b1;
					cur_valid_d   = 1'b1;
					cur_pos_d     = '0;
				end else begin
					streaming_d = 1'b0;
					state_d     = ST_SILENT;
				end
			end
			ST_SILENT: begin
				emit_d.valid  = 1'b1;
				emit_d.silent = 1'b1;
				emit_d.last   = last_sample;
				if (last_sample) begin
					state_d = ST_IDLE;
				end else begin
					frame_idx_d = frame_idx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== hdl/audio_jitter_buffer_playout.sv =====
`timescale 1ns / 1ps
// Push: busy for one cycle after acceptance, while the sample is written.
// Tick: results follow acceptance through the sequencer state and the registered
// emit and memory read, then one per cycle, except that a block pop from the queue
// or a found underrun holds the flow; busy until the frame's last sample is issued.
// Flush: taken in the accepting cycle, never busy. Results cannot be stalled.
// Reset empties the queue, staging and current block and sets the threshold to 6;
// the sample memory is left as it is.
module audio_jitter_buffer_playout #(
	parameter int BLOCK_SAMPLES = jbp_pkg::BLOCK_SAMPLES_DEF,
	parameter int QUEUE_BLOCKS  = jbp_pkg::QUEUE_BLOCKS_DEF,
	parameter int FRAME_SAMPLES = jbp_pkg::FRAME_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  jbp_pkg::in_item_t             item,
	output logic                          result_strobe,
	output jbp_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [jbp_pkg::THRESH_W-1:0]  cfg_data
);
	import jbp_pkg::*;

	localparam int DEPTH  = (QUEUE_BLOCKS + 2) * BLOCK_SAMPLES;
	localparam int ADDR_W = $clog2(DEPTH);

	mem_ctl_t            mem_ctl;
	logic [ADDR_W-1:0]   mem_addr;
	logic [SAMPLE_W-1:0] mem_wdata;
	logic [SAMPLE_W-1:0] mem_rdata;
	emit_t               emit;

	assign cfg_ready = 1'b1;

	jbp_seq #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES),
		.QUEUE_BLOCKS  (QUEUE_BLOCKS),
		.FRAME_SAMPLES (FRAME_SAMPLES),
		.ADDR_W        (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.emit      (emit)
	);

	jbp_sample_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		result_strobe     = emit.valid;
		result.pcm_out    = emit.silent ? '0 : $signed(mem_rdata);
		result.is_silence = emit.silent;
		result.last       = emit.last;
	end
endmodule

// ===== hdl/jbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the jitter buffer playout block, bound to the top level.
module jbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input jbp_pkg::in_item_t             item,
	input logic                          result_strobe,
	input jbp_pkg::out_item_t            result
);
	import jbp_pkg::*;

	a_work_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.command == CMD_PUSH || item.command == CMD_TICK) |=> busy)
		else $error("push or tick beat accepted without going busy");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == CMD_FLUSH |=> !busy)
		else $error("flush left the block busy");

	a_silence_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.is_silence |-> result.pcm_out == '0)
		else $error("silence beat carries a non-zero sample");

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		!result_strobe |-> !result.last && !result.is_silence)
		else $error("frame flags raised without a result beat");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> !busy)
		else $error("frame ended while the sequencer is still busy");
endmodule

bind audio_jitter_buffer_playout jbp_checker u_jbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.item          (item),
	.result_strobe (result_strobe),
	.result        (result)
);

// ===== tb/audio_jitter_buffer_playout_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the audio jitter buffer playout block.
module audio_jitter_buffer_playout_tb;
	import jbp_pkg::*;

	localparam logic [1:0] CMD_RSVD = 2'd3;
	localparam int BLK   = BLOCK_SAMPLES_DEF;
	localparam int QBLK  = QUEUE_BLOCKS_DEF;
	localparam int FRAME = FRAME_SAMPLES_DEF;
	localparam int ITEMS = 220;

	class playout_scoreboard;
		logic signed [SAMPLE_W-1:0] staging [BLK];
		logic signed [SAMPLE_W-1:0] ring [QBLK][BLK];
		logic signed [SAMPLE_W-1:0] playing [BLK];
		int head, tail, depth, stage_cnt, play_pos;
		bit play_valid, streaming;
		logic [THRESH_W-1:0] threshold;
		out_item_t samples_due [$];
		int errors;

		function new();
			threshold = THRESH_RESET;
			errors = 0;
			empty_all();
		endfunction

		function void empty_all();
			head = 0;
			tail = 0;
			depth = 0;
			stage_cnt = 0;
			play_pos = 0;
			play_valid = 0;
			streaming = 0;
		endfunction

		function void queue_sample(logic signed [SAMPLE_W-1:0] v, bit silent, int idx);
			out_item_t e;
			e.pcm_out = v;
			e.is_silence = silent;
			e.last = (idx == FRAME - 1);
			samples_due.push_back(e);
		endfunction

		function void take_item(in_item_t it);
			case (it.command)
				CMD_PUSH: begin
					staging[stage_cnt] = it.sample;
					stage_cnt++;
					if (stage_cnt == BLK) begin
						// drop the oldest block when the queue is full
						if (depth == QBLK) begin
							head = (head + 1) % QBLK;
							depth--;
						end
						ring[tail] = staging;
						tail = (tail + 1) % QBLK;
						depth++;
						stage_cnt = 0;
					end
				end
				CMD_TICK: begin
					if (!streaming && depth >= threshold)
						streaming = 1;
					for (int i = 0; i < FRAME; i++) begin
						if (streaming && !play_valid) begin
							if (depth > 0) begin
								playing = ring[head];
								head = (head + 1) % QBLK;
								depth--;
								play_valid = 1;
								play_pos = 0;
							end else begin
								streaming = 0;
							end
						end
						if (!streaming) begin
							queue_sample('0, 1'b1, i);
						end else begin
							queue_sample(playing[play_pos], 1'b0, i);
							play_pos++;
							if (play_pos == BLK) begin
								play_valid = 0;
								play_pos = 0;
							end
						end
					end
				end
				CMD_FLUSH: empty_all();
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t: mismatch: %s", $time, msg);
		endtask

		task check_sample(out_item_t got);
			out_item_t want;
			if (samples_due.size() == 0) begin
				report($sformatf("sample %h with nothing pending", got));
				return;
			end
			want = samples_due.pop_front();
			if (got.pcm_out !== want.pcm_out)
				report($sformatf("pcm_out %h, want %h", got.pcm_out, want.pcm_out));
			if (got.is_silence !== want.is_silence)
				report($sformatf("is_silence %b, want %b", got.is_silence, want.is_silence));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic result_strobe;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [THRESH_W-1:0] cfg_data;

	playout_scoreboard sb = new();
	int burst_left;
	bit gaps_on;
	int sent;

	audio_jitter_buffer_playout dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_strobe(result_strobe),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe)
				sb.check_sample(result);
			if (start && !busy)
				sb.take_item(item);
			if (cfg_valid && cfg_ready)
				sb.threshold = cfg_data;
		end
	end

	task automatic send_item(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		start <= 1'b1;
		item <= in_item_t'{cmd, smp};
		do @(posedge clk); while (busy);
		burst_left--;
		sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// hold until every pending sample is out and the block has gone quiet
	task automatic settle();
		go_idle();
		while (sb.samples_due.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THRESH_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int roll;
		logic signed [SAMPLE_W-1:0] smp;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		burst_left = 0;
		gaps_on = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// prebuffering silence, ignored command, extreme samples, flush
		send_item(CMD_TICK, 16'sh7fff);
		send_item(CMD_RSVD, 16'shffff);
		send_item(CMD_PUSH, 16'sh8000);
		send_item(CMD_PUSH, 16'sh7fff);
		send_item(CMD_PUSH, 16'sh0000);
		send_item(CMD_PUSH, 16'shffff);
		send_item(CMD_FLUSH, 16'shffff);
		send_item(CMD_TICK, 16'sh0000);
		// zero threshold: start at once, then underrun on the empty queue
		write_threshold(5'd0);
		send_item(CMD_TICK, 16'sh1234);
		send_item(CMD_TICK, 16'sh8000);
		send_item(CMD_PUSH, 16'sh5a5a);
		send_item(CMD_TICK, 16'sh0000);
		// threshold beyond the queue: never starts
		write_threshold(5'd31);
		send_item(CMD_TICK, 16'sh0000);
		send_item(CMD_PUSH, 16'sha5a5);
		send_item(CMD_TICK, 16'shffff);
		send_item(CMD_FLUSH, 16'sh0000);

		// fill one block at a threshold of one, with ticks mixed in
		write_threshold(5'd1);
		gaps_on = 1'b1;
		burst_left = 0;
		for (int n = 0; n < BLK; n++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(CMD_TICK, SAMPLE_W'($urandom));
			smp = SAMPLE_W'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: smp = 16'sh8000;
					1: smp = 16'sh7fff;
					2: smp = 16'sh0000;
					default: smp = 16'shffff;
				endcase
			end
			send_item(CMD_PUSH, smp);
		end
		// play the block out and run into underrun
		repeat (BLK / FRAME + 2) send_item(CMD_TICK, SAMPLE_W'($urandom));

		// random mix up to the item budget
		write_threshold(THRESH_W'($urandom_range(0, 31)));
		gaps_on = ($urandom_range(0, 3) != 0);
		burst_left = 0;
		while (sent < ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				settle();
			roll = $urandom_range(0, 99);
			if (roll < 55)
				send_item(CMD_PUSH, SAMPLE_W'($urandom));
			else if (roll < 90)
				send_item(CMD_TICK, SAMPLE_W'($urandom));
			else if (roll < 95)
				send_item(CMD_FLUSH, SAMPLE_W'($urandom));
			else
				send_item(CMD_RSVD, SAMPLE_W'($urandom));
		end

		go_idle();
		for (int w = 0; w < 4000 && (sb.samples_due.size() != 0 || busy); w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.samples_due.size() != 0)
			sb.report($sformatf("%0d samples never arrived", sb.samples_due.size()));
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
